@@ design/dct_pkg.sv @@
// Shared types, constants and saturating helpers for the dedup count table.
// Used by dct_lane, dct_merge and the top level; depends on nothing.
`timescale 1ns / 1ps

package dct_pkg;

    // defaults for the top-level parameters
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_MAX_COLUMNS = 8;
    localparam int DEF_VALUE_BITS  = 8;
    localparam int DEF_LANE_BITS   = 2;

    // fixed field widths
    localparam int COUNT_W   = 16;
    localparam int IN_LANE_W = 8;
    localparam int ROW_IN_W  = 64;
    localparam int SVAL_W    = 8;
    localparam int RIDX_W    = 8;
    localparam int COL_W     = 3;
    localparam int CFG_W     = 4;
    localparam int MODE_W    = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef logic [MODE_W-1:0] t_mode;
    localparam t_mode MODE_ADD    = 2'd0;
    localparam t_mode MODE_REMOVE = 2'd1;
    localparam t_mode MODE_COUNT  = 2'd2;
    localparam t_mode MODE_TOTALS = 2'd3;

    // per-lane compare result for the row read this cycle
    typedef struct packed {
        logic               live;
        logic               key_hit;
        logic               state_hit;
        logic [COUNT_W-1:0] count;
    } t_lane_stat;

    // merged result of one scan step
    typedef struct packed {
        logic               vld;
        logic               hit;
        logic [COUNT_W-1:0] hit_cnt;
        logic [COUNT_W-1:0] sum;
    } t_merge_res;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] a);
        return (a == COUNT_MAX) ? COUNT_MAX : a + COUNT_W'(1);
    endfunction

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
    endfunction

endpackage

@@ design/dct_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module dct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/dct_lane.sv @@
// One storage lane: a bank of rows and their repeat counts plus the row compare.
// Depends on dct_pkg and dct_ram.
`timescale 1ns / 1ps

module dct_lane import dct_pkg::*; #(
    parameter int BANK_DEPTH  = 64,
    parameter int ADDR_W      = 6,
    parameter int LANE_BITS   = 2,
    parameter int LANE_ID     = 0,
    parameter int MAX_COLUMNS = 8,
    parameter int VALUE_BITS  = 8,
    localparam int ROW_W = MAX_COLUMNS * VALUE_BITS,
    localparam int POS_W = ADDR_W + LANE_BITS
) (
    input  logic               i_clk,
    input  logic               i_re,
    input  logic [ADDR_W-1:0]  i_raddr,
    input  logic               i_row_we,
    input  logic               i_cnt_we,
    input  logic [ADDR_W-1:0]  i_waddr,
    input  logic [ROW_W-1:0]   i_row_wdata,
    input  logic [COUNT_W-1:0] i_cnt_wdata,
    input  logic [ADDR_W-1:0]  i_pos_addr,
    input  logic [ROW_W-1:0]   i_key,
    input  logic [ROW_W-1:0]   i_mask,
    input  logic [COL_W-1:0]   i_col,
    input  logic [SVAL_W-1:0]  i_sval,
    input  logic [POS_W:0]     i_stored,
    output t_lane_stat         o_stat,
    output logic [ROW_W-1:0]   o_row
);

    logic [ROW_W-1:0]      row_q;
    logic [COUNT_W-1:0]    cnt_q;
    logic [VALUE_BITS-1:0] fld;
    logic [POS_W:0]        pos_x;

    dct_ram #(.WIDTH(ROW_W), .DEPTH(BANK_DEPTH)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (i_row_we),
        .i_waddr (i_waddr),
        .i_wdata (i_row_wdata),
        .i_re    (i_re),
        .i_raddr (i_raddr),
        .o_rdata (row_q)
    );

    dct_ram #(.WIDTH(COUNT_W), .DEPTH(BANK_DEPTH)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (i_cnt_we),
        .i_waddr (i_waddr),
        .i_wdata (i_cnt_wdata),
        .i_re    (i_re),
        .i_raddr (i_raddr),
        .o_rdata (cnt_q)
    );

    always_comb begin
        fld = '0;
        for (int k = 0; k < MAX_COLUMNS; k++) begin
            if (i_col == COL_W'(k)) begin
                fld = row_q[k*VALUE_BITS +: VALUE_BITS];
            end
        end
        pos_x = {1'b0, i_pos_addr, LANE_BITS'(LANE_ID)};
        o_stat.live      = (pos_x < i_stored);
        o_stat.key_hit   = o_stat.live && ((row_q & i_mask) == i_key);
        o_stat.state_hit = o_stat.live && (SVAL_W'(fld) == i_sval);
        o_stat.count     = cnt_q;
    end

    assign o_row = row_q;

endmodule

@@ design/dct_merge.sv @@
// Merge stage: first matching lane and saturating sum of state hits, registered.
// Depends on dct_pkg.
`timescale 1ns / 1ps

module dct_merge import dct_pkg::*; #(
    parameter int LANE_BITS = 2,
    parameter int ADDR_W    = 6,
    localparam int LANES = 1 << LANE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [ADDR_W-1:0]    i_addr,
    input  t_lane_stat           i_stat [LANES],
    output t_merge_res           o_res,
    output logic [LANE_BITS-1:0] o_lane,
    output logic [ADDR_W-1:0]    o_addr
);

    logic                         hit;
    logic [LANE_BITS-1:0]         hit_lane;
    logic [COUNT_W-1:0]           hit_cnt;
    logic [COUNT_W+LANE_BITS-1:0] acc;
    logic [COUNT_W-1:0]           sum;

    logic                 r_vld;
    logic                 r_hit;
    logic [COUNT_W-1:0]   r_hit_cnt;
    logic [COUNT_W-1:0]   r_sum;
    logic [LANE_BITS-1:0] r_lane;
    logic [ADDR_W-1:0]    r_addr;

    always_comb begin
        hit      = 1'b0;
        hit_lane = '0;
        hit_cnt  = '0;
        acc      = '0;
        // walk down so the lowest matching lane wins
        for (int l = LANES - 1; l >= 0; l--) begin
            if (i_stat[l].key_hit) begin
                hit      = 1'b1;
                hit_lane = LANE_BITS'(l);
                hit_cnt  = i_stat[l].count;
            end
        end
        for (int l = 0; l < LANES; l++) begin
            if (i_stat[l].state_hit) begin
                acc = acc + (COUNT_W+LANE_BITS)'(i_stat[l].count);
            end
        end
        sum = (|acc[COUNT_W+LANE_BITS-1:COUNT_W]) ? COUNT_MAX : acc[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit     <= hit;
        r_hit_cnt <= hit_cnt;
        r_sum     <= sum;
        r_lane    <= hit_lane;
        r_addr    <= i_addr;
    end

    assign o_res.vld     = r_vld;
    assign o_res.hit     = r_hit;
    assign o_res.hit_cnt = r_hit_cnt;
    assign o_res.sum     = r_sum;
    assign o_lane        = r_lane;
    assign o_addr        = r_addr;

endmodule

@@ design/dedup_count_table_top.sv @@
// Top level of the dedup count table: control sequencer, lanes and merge stage.
// Depends on dct_pkg, dct_lane, dct_merge (and dct_ram through the lanes).
`timescale 1ns / 1ps

// Usage:
// A request is taken at a clock edge where start is high and busy is low; its
// fields are i_mode, i_row_values, i_row_index, i_column_index, i_state_value.
// Exactly one result follows, shown for one cycle with o_done high: o_ok,
// o_state_count, o_distinct_rows and o_total_rows. The receiver cannot stall;
// a result is gone after its cycle. busy drops in the cycle that o_done shows,
// so the next request may be taken at the end of that cycle.
// Rows are interleaved over LANES banks (row r in bank r mod LANES), and all
// banks are read at the same address each cycle, so one cycle covers LANES
// rows. Read totals, an out-of-range remove or count, and a count on an empty
// table are answered in the next cycle. Add row and count state scan from
// address 0 up to the last filled address (an add stops at the first match,
// and an add to an empty table appends without a scan); remove row scans from
// the address of row_index up to the last and moves the rows above it down.
// The bank read port sets the pace: one address per cycle.
// Reset empties the table, clears the totals and sets active_columns to 8; no
// clearing pass is needed because only rows below the fill count are used.
// i_cfg_we writes active_columns; write it only while the block is idle.
module dedup_count_table_top import dct_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS,
    parameter int LANE_BITS   = DEF_LANE_BITS,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    input  logic                start,
    output logic                busy,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [ROW_IN_W-1:0] i_row_values,
    input  logic [RIDX_W-1:0]   i_row_index,
    input  logic [COL_W-1:0]    i_column_index,
    input  logic [SVAL_W-1:0]   i_state_value,
    output logic                o_done,
    output logic                o_ok,
    output logic [COUNT_W-1:0]  o_state_count,
    output logic [CNT_W-1:0]    o_distinct_rows,
    output logic [COUNT_W-1:0]  o_total_rows
);

    localparam int LANES      = 1 << LANE_BITS;
    localparam int BANK_DEPTH = (TABLE_DEPTH + LANES - 1) / LANES;
    localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int POS_W      = ADDR_W + LANE_BITS;
    localparam int ROW_W      = MAX_COLUMNS * VALUE_BITS;
    localparam int CMP_W      = (POS_W + 1 > RIDX_W) ? POS_W + 1 : RIDX_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]           r_state,  n_state;
    t_mode                r_mode,   n_mode;
    logic [ROW_W-1:0]     r_key,    n_key;
    logic [COL_W-1:0]     r_col,    n_col;
    logic [SVAL_W-1:0]    r_sval,   n_sval;
    logic [POS_W-1:0]     r_rm_pos, n_rm_pos;
    logic                 r_iss,    n_iss;
    logic [ADDR_W-1:0]    r_rd_addr, n_rd_addr;
    logic                 r_p1_vld, n_p1_vld;
    logic [ADDR_W-1:0]    r_p1_addr, n_p1_addr;
    logic [COUNT_W-1:0]   r_acc,    n_acc;
    logic [COUNT_W-1:0]   r_rm_cnt, n_rm_cnt;
    logic [CNT_W-1:0]     r_stored, n_stored;
    logic [COUNT_W-1:0]   r_total,  n_total;
    logic [CFG_W-1:0]     r_active, n_active;
    logic                 r_done,   n_done;
    logic                 r_ok,     n_ok;
    logic [COUNT_W-1:0]   r_scnt,   n_scnt;

    logic [CFG_W-1:0]     live_cols;
    logic [ROW_W-1:0]     mask;
    logic [ROW_W-1:0]     in_key;
    logic [POS_W:0]       stored_x;
    logic [POS_W:0]       stored_m1;
    logic [ADDR_W-1:0]    last_addr;
    logic [ADDR_W-1:0]    app_addr;
    logic [LANE_BITS-1:0] app_lane;
    logic                 full;
    logic [POS_W-1:0]     in_pos;

    logic                 w_row_we [LANES];
    logic                 w_cnt_we [LANES];
    logic [ADDR_W-1:0]    w_addr   [LANES];
    logic [ROW_W-1:0]     w_row    [LANES];
    logic [COUNT_W-1:0]   w_cnt    [LANES];

    t_lane_stat           lane_stat [LANES];
    logic [ROW_W-1:0]     lane_row  [LANES];

    t_merge_res           m_res;
    logic [LANE_BITS-1:0] m_lane;
    logic [ADDR_W-1:0]    m_addr;

    // column count in use, and the packed, masked form of the incoming row
    always_comb begin
        live_cols = (r_active > CFG_W'(MAX_COLUMNS)) ? CFG_W'(MAX_COLUMNS) : r_active;
        mask      = '0;
        in_key    = '0;
        for (int k = 0; k < MAX_COLUMNS; k++) begin
            if (CFG_W'(k) < live_cols) begin
                mask[k*VALUE_BITS +: VALUE_BITS]   = '1;
                in_key[k*VALUE_BITS +: VALUE_BITS] = i_row_values[k*IN_LANE_W +: VALUE_BITS];
            end
        end
    end

    assign stored_x  = (POS_W+1)'(r_stored);
    assign stored_m1 = stored_x - (POS_W+1)'(1);
    assign last_addr = stored_m1[POS_W-1:LANE_BITS];
    assign app_addr  = stored_x[POS_W-1:LANE_BITS];
    assign app_lane  = stored_x[LANE_BITS-1:0];
    assign full      = (r_stored == CNT_W'(TABLE_DEPTH));
    assign in_pos    = POS_W'(i_row_index);

    generate
        for (genvar g = 0; g < LANES; g++) begin : g_lane
            dct_lane #(
                .BANK_DEPTH  (BANK_DEPTH),
                .ADDR_W      (ADDR_W),
                .LANE_BITS   (LANE_BITS),
                .LANE_ID     (g),
                .MAX_COLUMNS (MAX_COLUMNS),
                .VALUE_BITS  (VALUE_BITS)
            ) u_lane (
                .i_clk       (i_clk),
                .i_re        (r_iss),
                .i_raddr     (r_rd_addr),
                .i_row_we    (w_row_we[g]),
                .i_cnt_we    (w_cnt_we[g]),
                .i_waddr     (w_addr[g]),
                .i_row_wdata (w_row[g]),
                .i_cnt_wdata (w_cnt[g]),
                .i_pos_addr  (r_p1_addr),
                .i_key       (r_key),
                .i_mask      (mask),
                .i_col       (r_col),
                .i_sval      (r_sval),
                .i_stored    (stored_x),
                .o_stat      (lane_stat[g]),
                .o_row       (lane_row[g])
            );
        end
    endgenerate

    dct_merge #(
        .LANE_BITS (LANE_BITS),
        .ADDR_W    (ADDR_W)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p1_vld),
        .i_addr  (r_p1_addr),
        .i_stat  (lane_stat),
        .o_res   (m_res),
        .o_lane  (m_lane),
        .o_addr  (m_addr)
    );

    always_comb begin
        logic             finish;
        logic             do_append;
        logic [COUNT_W-1:0] acc_sum;
        logic [COUNT_W-1:0] cur_cnt;
        logic [POS_W:0]   rm_x;
        logic [POS_W:0]   pos_x;
        logic [POS_W:0]   base_x;

        n_state   = r_state;
        n_mode    = r_mode;
        n_key     = r_key;
        n_col     = r_col;
        n_sval    = r_sval;
        n_rm_pos  = r_rm_pos;
        n_iss     = r_iss;
        n_rd_addr = r_rd_addr;
        n_p1_vld  = r_iss;
        n_p1_addr = r_rd_addr;
        n_acc     = r_acc;
        n_rm_cnt  = r_rm_cnt;
        n_stored  = r_stored;
        n_total   = r_total;
        n_active  = i_cfg_we ? i_cfg_wdata : r_active;
        n_done    = 1'b0;
        n_ok      = r_ok;
        n_scnt    = r_scnt;

        finish    = 1'b0;
        do_append = 1'b0;
        acc_sum   = '0;
        cur_cnt   = r_rm_cnt;
        rm_x      = {1'b0, r_rm_pos};
        pos_x     = '0;
        base_x    = '0;

        for (int l = 0; l < LANES; l++) begin
            w_row_we[l] = 1'b0;
            w_cnt_we[l] = 1'b0;
            w_addr[l]   = '0;
            w_row[l]    = r_key;
            w_cnt[l]    = COUNT_W'(1);
        end

        // issue bank reads, one address per cycle
        if (r_iss) begin
            if (r_rd_addr == last_addr) begin
                n_iss = 1'b0;
            end else begin
                n_rd_addr = r_rd_addr + ADDR_W'(1);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mode    = i_mode;
                    n_key     = in_key;
                    n_col     = i_column_index;
                    n_sval    = i_state_value;
                    n_rm_pos  = in_pos;
                    n_acc     = '0;
                    n_rd_addr = '0;
                    case (i_mode)
                        MODE_ADD: begin
                            n_state = S_SCAN;
                            n_iss   = (r_stored != '0);
                        end
                        MODE_REMOVE: begin
                            if (CMP_W'(i_row_index) >= CMP_W'(r_stored)) begin
                                n_done = 1'b1;
                                n_ok   = 1'b0;
                                n_scnt = '0;
                            end else begin
                                n_state   = S_SHIFT;
                                n_iss     = 1'b1;
                                n_rd_addr = in_pos[POS_W-1:LANE_BITS];
                            end
                        end
                        MODE_COUNT: begin
                            if (CFG_W'(i_column_index) >= live_cols) begin
                                n_done = 1'b1;
                                n_ok   = 1'b0;
                                n_scnt = '0;
                            end else if (r_stored == '0) begin
                                n_done = 1'b1;
                                n_ok   = 1'b1;
                                n_scnt = '0;
                            end else begin
                                n_state = S_SCAN;
                                n_iss   = 1'b1;
                            end
                        end
                        MODE_TOTALS: begin
                            n_done = 1'b1;
                            n_ok   = 1'b1;
                            n_scnt = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (r_mode == MODE_ADD) begin
                    n_scnt = '0;
                    if (r_stored == '0) begin
                        do_append = 1'b1;
                    end else if (m_res.vld && m_res.hit) begin
                        // bump the first matching row
                        w_cnt_we[m_lane] = 1'b1;
                        w_addr[m_lane]   = m_addr;
                        w_cnt[m_lane]    = sat_inc(m_res.hit_cnt);
                        n_total          = sat_inc(r_total);
                        n_ok             = 1'b1;
                        finish           = 1'b1;
                    end else if (m_res.vld && (m_addr == last_addr)) begin
                        if (full) begin
                            n_ok   = 1'b0;
                            finish = 1'b1;
                        end else begin
                            do_append = 1'b1;
                        end
                    end
                    if (do_append) begin
                        w_row_we[app_lane] = 1'b1;
                        w_cnt_we[app_lane] = 1'b1;
                        w_addr[app_lane]   = app_addr;
                        n_stored           = r_stored + CNT_W'(1);
                        n_total            = sat_inc(r_total);
                        n_ok               = 1'b1;
                        finish             = 1'b1;
                    end
                end else begin
                    if (m_res.vld) begin
                        acc_sum = sat_add(r_acc, m_res.sum);
                        n_acc   = acc_sum;
                        if (m_addr == last_addr) begin
                            n_ok   = 1'b1;
                            n_scnt = acc_sum;
                            finish = 1'b1;
                        end
                    end
                end
            end

            S_SHIFT: begin
                if (r_p1_vld) begin
                    // move each row above the removed one down by one place
                    for (int l = 0; l < LANES - 1; l++) begin
                        pos_x = {1'b0, r_p1_addr, LANE_BITS'(l)};
                        if ((pos_x >= rm_x) && (pos_x + (POS_W+1)'(1) < stored_x)) begin
                            w_row_we[l] = 1'b1;
                            w_cnt_we[l] = 1'b1;
                            w_addr[l]   = r_p1_addr;
                            w_row[l]    = lane_row[l+1];
                            w_cnt[l]    = lane_stat[l+1].count;
                        end
                    end
                    // the top lane takes lane 0 of this address into the previous one
                    base_x = {1'b0, r_p1_addr, LANE_BITS'(0)};
                    if ((base_x > rm_x) && (base_x < stored_x)) begin
                        w_row_we[LANES-1] = 1'b1;
                        w_cnt_we[LANES-1] = 1'b1;
                        w_addr[LANES-1]   = r_p1_addr - ADDR_W'(1);
                        w_row[LANES-1]    = lane_row[0];
                        w_cnt[LANES-1]    = lane_stat[0].count;
                    end
                    if (r_p1_addr == r_rm_pos[POS_W-1:LANE_BITS]) begin
                        cur_cnt  = lane_stat[r_rm_pos[LANE_BITS-1:0]].count;
                        n_rm_cnt = cur_cnt;
                    end
                    if (r_p1_addr == last_addr) begin
                        n_stored = r_stored - CNT_W'(1);
                        n_total  = (r_total > cur_cnt) ? r_total - cur_cnt : '0;
                        n_ok     = 1'b1;
                        n_scnt   = '0;
                        finish   = 1'b1;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (finish) begin
            n_state  = S_IDLE;
            n_done   = 1'b1;
            n_iss    = 1'b0;
            n_p1_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_iss    <= 1'b0;
            r_p1_vld <= 1'b0;
            r_stored <= '0;
            r_total  <= '0;
            r_active <= CFG_W'(8);
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_iss    <= n_iss;
            r_p1_vld <= n_p1_vld;
            r_stored <= n_stored;
            r_total  <= n_total;
            r_active <= n_active;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_key     <= n_key;
        r_col     <= n_col;
        r_sval    <= n_sval;
        r_rm_pos  <= n_rm_pos;
        r_rd_addr <= n_rd_addr;
        r_p1_addr <= n_p1_addr;
        r_acc     <= n_acc;
        r_rm_cnt  <= n_rm_cnt;
        r_ok      <= n_ok;
        r_scnt    <= n_scnt;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_ok            = r_ok;
    assign o_state_count   = r_scnt;
    assign o_distinct_rows = r_stored;
    assign o_total_rows    = r_total;

endmodule
